>>> rtl/mcdr_pkg.sv
// Shared constants, command codes and the CORDIC arctangent table for the
// motor command dead reckoning block. No dependencies.
`timescale 1ns / 1ps

package mcdr_pkg;

    // Build-time configuration
    localparam int CORDIC_STEPS  = 16;
    localparam int POSITION_BITS = 32;

    // CORDIC sizing
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(CORDIC_ITERS);
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
    localparam int CS_W         = 34;   // Q2.30 cosine/sine with guard bits
    localparam int Z_W          = 33;   // residual angle accumulator
    localparam logic signed [CS_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

    // Distance and displacement widths
    localparam int DIST_W = 40;         // scaled distance, Q24.16
    localparam int MAG_W  = 42;         // one displacement magnitude

    // Command codes
    localparam logic [2:0] KIND_FORWARD = 3'd0;
    localparam logic [2:0] KIND_BACK    = 3'd1;
    localparam logic [2:0] KIND_LEFT    = 3'd2;
    localparam logic [2:0] KIND_RIGHT   = 3'd3;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_DISTANCE_GAIN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_GAIN     = 1'b1;

    // Arctangent of 2^-i in binary-angle units
    function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/mcdr_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then a
// quadrant fix-up. Depends on mcdr_pkg.
`timescale 1ns / 1ps

module mcdr_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [31:0]                          angle,
    output logic                                 done,
    output logic signed [mcdr_pkg::CS_W-1:0]     cos_out,
    output logic signed [mcdr_pkg::CS_W-1:0]     sin_out
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_ROT} cstate_t;

    cstate_t                                state_reg;
    logic [mcdr_pkg::STEP_W-1:0]            step_reg;
    logic [1:0]                             quad_reg;
    logic signed [mcdr_pkg::CS_W-1:0]       x_reg;
    logic signed [mcdr_pkg::CS_W-1:0]       y_reg;
    logic signed [mcdr_pkg::Z_W-1:0]        z_reg;
    logic signed [mcdr_pkg::CS_W-1:0]       cos_reg;
    logic signed [mcdr_pkg::CS_W-1:0]       sin_reg;
    logic                                   done_reg;

    logic [31:0]                            quad_sum;
    logic [1:0]                             quad_in;
    logic [31:0]                            residual;
    logic signed [mcdr_pkg::CS_W-1:0]       x_shift;
    logic signed [mcdr_pkg::CS_W-1:0]       y_shift;
    logic signed [mcdr_pkg::Z_W-1:0]        atan_z;

    // Split the angle into a quadrant and a signed residual
    assign quad_sum = angle + 32'h2000_0000;
    assign quad_in  = quad_sum[31:30];
    assign residual = angle - {quad_in, 30'b0};

    // Shared shifter and table lookup for the current step
    always_comb
    begin
        x_shift = x_reg >>> step_reg;
        y_shift = y_reg >>> step_reg;
        atan_z  = signed'(mcdr_pkg::Z_W'(
                      mcdr_pkg::atan_entry(mcdr_pkg::ATAN_IDX_W'(step_reg))));
    end

    // Sequence the micro-rotations and the quadrant fix-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            quad_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            cos_reg   <= '0;
            sin_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // pulse done for one cycle as the fix-up lands
            done_reg <= (state_reg == C_ROT);
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        quad_reg  <= quad_in;
                        z_reg     <= mcdr_pkg::Z_W'(signed'(residual));
                        x_reg     <= mcdr_pkg::INV_GAIN_Q30;
                        y_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    if (!z_reg[mcdr_pkg::Z_W-1])
                    begin
                        x_reg <= x_reg - y_shift;
                        y_reg <= y_reg + x_shift;
                        z_reg <= z_reg - atan_z;
                    end
                    else
                    begin
                        x_reg <= x_reg + y_shift;
                        y_reg <= y_reg - x_shift;
                        z_reg <= z_reg + atan_z;
                    end
                    if (step_reg == mcdr_pkg::STEP_W'(mcdr_pkg::CORDIC_ITERS - 1))
                        state_reg <= C_ROT;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                C_ROT:
                begin
                    case (quad_reg)
                        2'd0:
                        begin
                            cos_reg <= x_reg;
                            sin_reg <= y_reg;
                        end
                        2'd1:
                        begin
                            cos_reg <= -y_reg;
                            sin_reg <= x_reg;
                        end
                        2'd2:
                        begin
                            cos_reg <= -x_reg;
                            sin_reg <= -y_reg;
                        end
                        default:
                        begin
                            cos_reg <= y_reg;
                            sin_reg <= -x_reg;
                        end
                    endcase
                    state_reg <= C_IDLE;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

>>> rtl/motor_command_dead_reckoning.sv
// Motor command decoder with open-loop dead reckoning pose tracking.
// Depends on mcdr_pkg and mcdr_cordic.
// Moves pass through the CORDIC loop and the single shared 32x32 multiplier;
// turns use only the multiplier. Ready only when idle, so a new command is
// taken only after the last result has loaded into the output register.
// Reset clears the pose, direction levels and handshakes; gains reset to defaults.
`timescale 1ns / 1ps

module motor_command_dead_reckoning (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [mcdr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [31:0]                       cfg_wdata,
    // command channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        kind,
    input  logic [7:0]                        speed,
    input  logic [15:0]                       duration_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              dir_left,
    output logic                              dir_right,
    output logic [7:0]                        duty,
    output logic signed [31:0]                pos_x,
    output logic signed [31:0]                pos_y,
    output logic [31:0]                       heading
);

    localparam int PB     = mcdr_pkg::POSITION_BITS;
    localparam int MOVE_W = ((PB > mcdr_pkg::MAG_W) ? PB : mcdr_pkg::MAG_W) + 2;
    localparam logic signed [MOVE_W-1:0] POS_MAX =
        (MOVE_W'(1) <<< (PB - 1)) - MOVE_W'(1);
    localparam logic signed [MOVE_W-1:0] POS_MIN = -(MOVE_W'(1) <<< (PB - 1));

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_DIST, S_CORD, S_MHI, S_MLO, S_MOVE,
        S_TURN, S_HEAD, S_WRITE
    } state_t;

    state_t                           state_reg;
    logic [31:0]                      distance_gain_reg;
    logic [31:0]                      turn_gain_reg;
    logic [2:0]                       kind_reg;
    logic [7:0]                       speed_reg;
    logic [15:0]                      dur_reg;
    logic [23:0]                      prod_reg;
    logic [mcdr_pkg::DIST_W-1:0]      d_reg;
    logic [31:0]                      delta_reg;
    logic [31:0]                      xmag_reg;
    logic [31:0]                      ymag_reg;
    logic                             xneg_reg;
    logic                             yneg_reg;
    logic                             axis_reg;
    logic [55:0]                      phi_reg;
    logic [mcdr_pkg::MAG_W-1:0]       m_reg;
    logic signed [PB-1:0]             x_reg;
    logic signed [PB-1:0]             y_reg;
    logic [31:0]                      heading_reg;
    logic                             left_dir_reg;
    logic                             right_dir_reg;
    logic                             out_valid_reg;
    logic                             dir_left_reg;
    logic                             dir_right_reg;
    logic [7:0]                       duty_reg;
    logic signed [31:0]               pos_x_reg;
    logic signed [31:0]               pos_y_reg;
    logic [31:0]                      heading_out_reg;

    logic [31:0]                      mul_a;
    logic [31:0]                      mul_b;
    logic [63:0]                      mul_p;
    logic [31:0]                      cmag;
    logic [71:0]                      scale_sum;
    logic signed [MOVE_W-1:0]         pos_ext;
    logic signed [MOVE_W-1:0]         m_ext;
    logic signed [MOVE_W-1:0]         pos_raw;
    logic signed [PB-1:0]             pos_next;
    logic signed [MOVE_W-1:0]         x_wide;
    logic signed [MOVE_W-1:0]         y_wide;
    logic                             is_back;
    logic                             is_active;

    logic                             cordic_done;
    logic signed [mcdr_pkg::CS_W-1:0] cos_val;
    logic signed [mcdr_pkg::CS_W-1:0] sin_val;
    logic signed [mcdr_pkg::CS_W-1:0] cos_abs;
    logic signed [mcdr_pkg::CS_W-1:0] sin_abs;

    assign in_ready  = (state_reg == S_IDLE);
    assign is_back   = (kind_reg == mcdr_pkg::KIND_BACK);
    assign is_active = (kind_reg <= mcdr_pkg::KIND_RIGHT);

    // Hold gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_gain_reg <= 32'd1349264;
            turn_gain_reg     <= 32'd21474;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mcdr_pkg::REG_DISTANCE_GAIN: distance_gain_reg <= cfg_wdata;
                mcdr_pkg::REG_TURN_GAIN:     turn_gain_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Cosine and sine of the current heading
    mcdr_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_DIST),
        .angle   (heading_reg),
        .done    (cordic_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    assign cos_abs = cos_val[mcdr_pkg::CS_W-1] ? -cos_val : cos_val;
    assign sin_abs = sin_val[mcdr_pkg::CS_W-1] ? -sin_val : sin_val;

    // Select operands for the shared multiplier
    assign cmag = axis_reg ? ymag_reg : xmag_reg;

    always_comb
    begin
        case (state_reg)
            S_PROD:
            begin
                mul_a = 32'(speed_reg);
                mul_b = 32'(dur_reg);
            end
            S_DIST:
            begin
                mul_a = 32'(prod_reg);
                mul_b = distance_gain_reg;
            end
            S_TURN:
            begin
                mul_a = 32'(prod_reg);
                mul_b = turn_gain_reg;
            end
            S_MHI:
            begin
                mul_a = 32'(d_reg[mcdr_pkg::DIST_W-1:16]);
                mul_b = cmag;
            end
            S_MLO:
            begin
                mul_a = 32'(d_reg[15:0]);
                mul_b = cmag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
    end

    // Combine partial products into a rounded displacement
    assign scale_sum = {phi_reg, 16'b0} + 72'(mul_p[47:0]) + 72'h2000_0000;

    // Apply one displacement with saturation
    always_comb
    begin
        pos_ext = MOVE_W'(axis_reg ? y_reg : x_reg);
        m_ext   = signed'(MOVE_W'(m_reg));
        if (axis_reg ? yneg_reg : xneg_reg)
            pos_raw = pos_ext - m_ext;
        else
            pos_raw = pos_ext + m_ext;
        if (pos_raw > POS_MAX)
            pos_next = PB'(POS_MAX);
        else if (pos_raw < POS_MIN)
            pos_next = PB'(POS_MIN);
        else
            pos_next = PB'(pos_raw);
        x_wide = MOVE_W'(x_reg);
        y_wide = MOVE_W'(y_reg);
    end

    // Sequence one command through the shared datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            x_reg           <= '0;
            y_reg           <= '0;
            heading_reg     <= '0;
            left_dir_reg    <= 1'b0;
            right_dir_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            axis_reg        <= 1'b0;
            kind_reg        <= '0;
            speed_reg       <= '0;
            dur_reg         <= '0;
            prod_reg        <= '0;
            d_reg           <= '0;
            delta_reg       <= '0;
            xmag_reg        <= '0;
            ymag_reg        <= '0;
            xneg_reg        <= 1'b0;
            yneg_reg        <= 1'b0;
            phi_reg         <= '0;
            m_reg           <= '0;
            dir_left_reg    <= 1'b0;
            dir_right_reg   <= 1'b0;
            duty_reg        <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            heading_out_reg <= '0;
        end
        else
        begin
            // drop the result once transferred, unless a new one loads now
            if (out_valid_reg && out_ready && (state_reg != S_WRITE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind;
                        speed_reg <= speed;
                        dur_reg   <= duration_ms;
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    prod_reg <= mul_p[23:0];
                    case (kind_reg)
                        mcdr_pkg::KIND_FORWARD:
                        begin
                            left_dir_reg  <= 1'b0;
                            right_dir_reg <= 1'b0;
                            state_reg     <= S_DIST;
                        end
                        mcdr_pkg::KIND_BACK:
                        begin
                            left_dir_reg  <= 1'b1;
                            right_dir_reg <= 1'b1;
                            state_reg     <= S_DIST;
                        end
                        mcdr_pkg::KIND_LEFT:
                        begin
                            left_dir_reg  <= 1'b1;
                            right_dir_reg <= 1'b0;
                            state_reg     <= S_TURN;
                        end
                        mcdr_pkg::KIND_RIGHT:
                        begin
                            left_dir_reg  <= 1'b0;
                            right_dir_reg <= 1'b1;
                            state_reg     <= S_TURN;
                        end
                        default:
                            state_reg <= S_WRITE;
                    endcase
                end
                S_DIST:
                begin
                    d_reg     <= mcdr_pkg::DIST_W'((mul_p[55:0] + 56'h8000) >> 16);
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (cordic_done)
                    begin
                        xmag_reg  <= cos_abs[31:0];
                        ymag_reg  <= sin_abs[31:0];
                        xneg_reg  <= cos_val[mcdr_pkg::CS_W-1] ^ is_back;
                        yneg_reg  <= sin_val[mcdr_pkg::CS_W-1] ^ is_back;
                        axis_reg  <= 1'b0;
                        state_reg <= S_MHI;
                    end
                end
                S_MHI:
                begin
                    phi_reg   <= mul_p[55:0];
                    state_reg <= S_MLO;
                end
                S_MLO:
                begin
                    m_reg     <= mcdr_pkg::MAG_W'(scale_sum >> 30);
                    state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    if (axis_reg)
                    begin
                        y_reg     <= pos_next;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        x_reg     <= pos_next;
                        axis_reg  <= 1'b1;
                        state_reg <= S_MHI;
                    end
                end
                S_TURN:
                begin
                    delta_reg <= mul_p[31:0];
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    if (kind_reg == mcdr_pkg::KIND_LEFT)
                        heading_reg <= heading_reg + delta_reg;
                    else
                        heading_reg <= heading_reg - delta_reg;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    // load the result once the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        dir_left_reg    <= left_dir_reg;
                        dir_right_reg   <= right_dir_reg;
                        duty_reg        <= is_active ? speed_reg : 8'd0;
                        pos_x_reg       <= x_wide[31:0];
                        pos_y_reg       <= y_wide[31:0];
                        heading_out_reg <= heading_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign dir_left  = dir_left_reg;
    assign dir_right = dir_right_reg;
    assign duty      = duty_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_out_reg;

endmodule
